// ----- rtl/a2b_pkg.sv -----
package a2b_pkg;

	localparam int CHAR_W = 8;
	localparam int CODE_W = 5;

	// output queue depth; one character adds at most two codes
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_IDX_W = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

	// baudot control codes
	localparam logic [CODE_W-1:0] CODE_LTRS  = 5'd31;
	localparam logic [CODE_W-1:0] CODE_FIGS  = 5'd27;
	localparam logic [CODE_W-1:0] CODE_CR    = 5'd8;
	localparam logic [CODE_W-1:0] CODE_LF    = 5'd2;
	localparam logic [CODE_W-1:0] CODE_SPACE = 5'd4;
	localparam logic [CODE_W-1:0] CODE_NUL   = 5'd0;

	// ascii characters with a fixed treatment
	localparam logic [CHAR_W-1:0] ASCII_NUL     = 8'h00;
	localparam logic [CHAR_W-1:0] ASCII_CR      = 8'h0D;
	localparam logic [CHAR_W-1:0] ASCII_LF      = 8'h0A;
	localparam logic [CHAR_W-1:0] ASCII_SPACE   = 8'h20;
	localparam logic [CHAR_W-1:0] ASCII_LOWER_A = 8'h61;
	localparam logic [CHAR_W-1:0] ASCII_LOWER_Z = 8'h7A;
	localparam logic [CHAR_W-1:0] ASCII_CASE    = 8'h20;

	typedef enum logic [1:0] {
		SHIFT_LETTERS = 2'd0,
		SHIFT_FIGURES = 2'd1,
		SHIFT_UNKNOWN = 2'd2
	} shift_t;

	typedef struct packed {
		logic              hit;
		logic [CODE_W-1:0] code;
	} lookup_t;

	typedef struct packed {
		logic [CODE_W-1:0] code;
		logic              last;
	} queue_ent_t;

	// letters shift table, upper case only
	function automatic lookup_t lookup_letter(input logic [CHAR_W-1:0] ch);
		lookup_t r;
		r.hit = 1'b1;
		unique case (ch)
			8'h45: r.code = 5'd1;   // E
			8'h41: r.code = 5'd3;   // A
			8'h53: r.code = 5'd5;   // S
			8'h49: r.code = 5'd6;   // I
			8'h55: r.code = 5'd7;   // U
			8'h44: r.code = 5'd9;   // D
			8'h52: r.code = 5'd10;  // R
			8'h4A: r.code = 5'd11;  // J
			8'h4E: r.code = 5'd12;  // N
			8'h46: r.code = 5'd13;  // F
			8'h43: r.code = 5'd14;  // C
			8'h4B: r.code = 5'd15;  // K
			8'h54: r.code = 5'd16;  // T
			8'h5A: r.code = 5'd17;  // Z
			8'h4C: r.code = 5'd18;  // L
			8'h57: r.code = 5'd19;  // W
			8'h48: r.code = 5'd20;  // H
			8'h59: r.code = 5'd21;  // Y
			8'h50: r.code = 5'd22;  // P
			8'h51: r.code = 5'd23;  // Q
			8'h4F: r.code = 5'd24;  // O
			8'h42: r.code = 5'd25;  // B
			8'h47: r.code = 5'd26;  // G
			8'h4D: r.code = 5'd28;  // M
			8'h58: r.code = 5'd29;  // X
			8'h56: r.code = 5'd30;  // V
			default: begin
				r.hit  = 1'b0;
				r.code = CODE_NUL;
			end
		endcase
		return r;
	endfunction

	// figures shift table
	function automatic lookup_t lookup_figure(input logic [CHAR_W-1:0] ch);
		lookup_t r;
		r.hit = 1'b1;
		unique case (ch)
			8'h33: r.code = 5'd1;   // 3
			8'h2D: r.code = 5'd3;   // -
			8'h07: r.code = 5'd5;   // bell
			8'h38: r.code = 5'd6;   // 8
			8'h37: r.code = 5'd7;   // 7
			8'h24: r.code = 5'd9;   // $
			8'h34: r.code = 5'd10;  // 4
			8'h27: r.code = 5'd11;  // apostrophe
			8'h2C: r.code = 5'd12;  // comma
			8'h21: r.code = 5'd13;  // !
			8'h3A: r.code = 5'd14;  // :
			8'h28: r.code = 5'd15;  // (
			8'h35: r.code = 5'd16;  // 5
			8'h22: r.code = 5'd17;  // double quote
			8'h29: r.code = 5'd18;  // )
			8'h32: r.code = 5'd19;  // 2
			8'h36: r.code = 5'd21;  // 6
			8'h30: r.code = 5'd22;  // 0
			8'h31: r.code = 5'd23;  // 1
			8'h39: r.code = 5'd24;  // 9
			8'h3F: r.code = 5'd25;  // ?
			8'h26: r.code = 5'd26;  // &
			8'h2E: r.code = 5'd28;  // .
			8'h2F: r.code = 5'd29;  // /
			8'h3B: r.code = 5'd30;  // ;
			default: begin
				r.hit  = 1'b0;
				r.code = CODE_NUL;
			end
		endcase
		return r;
	endfunction

endpackage

// ----- rtl/a2b_char_if.sv -----
interface a2b_char_if
	import a2b_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] ascii_char;
	logic              resync_shift;

	modport source (output valid, output ascii_char, output resync_shift, input ready);
	modport sink (input valid, input ascii_char, input resync_shift, output ready);
endinterface

// ----- rtl/a2b_code_if.sv -----
interface a2b_code_if
	import a2b_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [CODE_W-1:0] baudot_code;
	logic              last_of_run;

	modport source (output valid, output baudot_code, output last_of_run, input ready);
	modport sink (input valid, input baudot_code, input last_of_run, output ready);
endinterface

// ----- rtl/ascii_to_baudot_encoder.sv -----
// ascii to baudot encoder: one character beat in, zero to two code beats out
// path: the character is held in the stage 1 input register, and its codes are
// written to the code queue when it has room for two; the queue head offers them
// throughput: one code per cycle while the receiver is ready, set by the single
// output port of the four-entry code queue; so one character per cycle for
// single-code characters, while one that needs a shift code or is newline adds two
// reset: queue and input stage empty, shift state unknown
module ascii_to_baudot_encoder
	import a2b_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	a2b_char_if.sink   src_ch,
	a2b_code_if.source res_ch
);

	logic              valid_s1;
	logic [CHAR_W-1:0] char_s1;
	logic              resync_s1;

	shift_t shift_q;

	queue_ent_t             queue_q [QUEUE_DEPTH];
	logic [QUEUE_IDX_W-1:0] wr_ptr_q;
	logic [QUEUE_IDX_W-1:0] rd_ptr_q;
	logic [QUEUE_CNT_W-1:0] count_q;

	logic              advance;
	logic              pop;
	logic [1:0]        push_n;
	queue_ent_t        ent0;
	queue_ent_t        ent1;
	shift_t            shift_next;
	logic [CHAR_W-1:0] char_up;
	shift_t            shift_eff;
	lookup_t           let_hit;
	lookup_t           fig_hit;

	// stage 1 moves on when the queue has room for two codes
	assign advance = valid_s1 && (count_q <= QUEUE_CNT_W'(QUEUE_DEPTH - 2));
	assign src_ch.ready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (src_ch.ready) begin
			valid_s1 <= src_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (src_ch.valid && src_ch.ready) begin
			char_s1   <= src_ch.ascii_char;
			resync_s1 <= src_ch.resync_shift;
		end
	end

	// fold case and look up both shift tables
	always_comb begin
		char_up = char_s1;
		if (char_s1 >= ASCII_LOWER_A && char_s1 <= ASCII_LOWER_Z) begin
			char_up = char_s1 - ASCII_CASE;
		end
		shift_eff = resync_s1 ? SHIFT_UNKNOWN : shift_q;
		let_hit   = lookup_letter(char_up);
		fig_hit   = lookup_figure(char_up);
	end

	// encode into up to two codes and the next shift state
	always_comb begin
		push_n     = 2'd0;
		ent0       = '{code: CODE_NUL, last: 1'b1};
		ent1       = '{code: CODE_NUL, last: 1'b1};
		shift_next = shift_eff;
		if (char_up == ASCII_NUL) begin
			push_n = 2'd1;
		end else if (char_up == ASCII_CR) begin
			push_n    = 2'd1;
			ent0.code = CODE_CR;
		end else if (char_up == ASCII_LF) begin
			push_n    = 2'd2;
			ent0      = '{code: CODE_CR, last: 1'b0};
			ent1.code = CODE_LF;
		end else if (char_up == ASCII_SPACE) begin
			push_n    = 2'd1;
			ent0.code = CODE_SPACE;
		end else if (let_hit.hit) begin
			shift_next = SHIFT_LETTERS;
			if (shift_eff != SHIFT_LETTERS) begin
				push_n    = 2'd2;
				ent0      = '{code: CODE_LTRS, last: 1'b0};
				ent1.code = let_hit.code;
			end else begin
				push_n    = 2'd1;
				ent0.code = let_hit.code;
			end
		end else if (fig_hit.hit) begin
			shift_next = SHIFT_FIGURES;
			if (shift_eff != SHIFT_FIGURES) begin
				push_n    = 2'd2;
				ent0      = '{code: CODE_FIGS, last: 1'b0};
				ent1.code = fig_hit.code;
			end else begin
				push_n    = 2'd1;
				ent0.code = fig_hit.code;
			end
		end
	end

	// shift state and queue control
	assign pop = (count_q != '0) && res_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q  <= SHIFT_UNKNOWN;
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (advance) begin
				shift_q  <= shift_next;
				wr_ptr_q <= wr_ptr_q + QUEUE_IDX_W'(push_n);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QUEUE_IDX_W'(1);
			end
			count_q <= count_q + (advance ? QUEUE_CNT_W'(push_n) : '0)
				- QUEUE_CNT_W'(pop);
		end
	end

	// queue storage
	always_ff @(posedge clk) begin
		if (advance && push_n != 2'd0) begin
			queue_q[wr_ptr_q] <= ent0;
		end
		if (advance && push_n == 2'd2) begin
			queue_q[wr_ptr_q + QUEUE_IDX_W'(1)] <= ent1;
		end
	end

	// result beat from queue head
	assign res_ch.valid       = (count_q != '0);
	assign res_ch.baudot_code = queue_q[rd_ptr_q].code;
	assign res_ch.last_of_run = queue_q[rd_ptr_q].last;

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
	import a2b_pkg::*;

	// letters and figures rows, indexed by baudot code, zero marks an empty slot
	localparam logic [8*31-1:0] LETTER_ROW = "\000E\000A\000SIU\000DRJNFCKTZLWHYPQOBG\000MXV";
	localparam logic [8*31-1:0] FIGURE_ROW = "\0003\000-\000\00787\000$4',!:(5\")2\0006019?&\000./;";

	localparam int RANDOM_HITS = 500;
	localparam int TAIL_CYCLES = 16;

	// one row of the directed table; typed rows carry their expected codes
	typedef struct packed {
		logic [CHAR_W-1:0] ch;
		logic              rs;
		logic              typed;
		logic [1:0]        n;
		logic [CODE_W-1:0] c0;
		logic              l0;
		logic [CODE_W-1:0] c1;
		logic              l1;
	} dir_row_t;

	localparam int DIR_ROWS = 25;

	dir_row_t dir_rows [DIR_ROWS] = '{
		'{8'h41, 1'b0, 1'b1, 2'd2, CODE_LTRS,  1'b0, 5'd3,     1'b1},
		'{8'h61, 1'b0, 1'b0, 2'd0, CODE_NUL,   1'b0, CODE_NUL, 1'b0},
		'{8'h7A, 1'b0, 1'b0, 2'd0, CODE_NUL,   1'b0, CODE_NUL, 1'b0},
		'{8'h00, 1'b0, 1'b1, 2'd1, CODE_NUL,   1'b1, CODE_NUL, 1'b0},
		'{8'hFF, 1'b0, 1'b1, 2'd0, CODE_NUL,   1'b0, CODE_NUL, 1'b0},
		'{8'h80, 1'b0, 1'b1, 2'd0, CODE_NUL,   1'b0, CODE_NUL, 1'b0},
		'{8'h30, 1'b0, 1'b0, 2'd0, CODE_NUL,   1'b0, CODE_NUL, 1'b0},
		'{8'h07, 1'b0, 1'b0, 2'd0, CODE_NUL,   1'b0, CODE_NUL, 1'b0},
		'{8'h0D, 1'b0, 1'b1, 2'd1, CODE_CR,    1'b1, CODE_NUL, 1'b0},
		'{8'h0A, 1'b0, 1'b1, 2'd2, CODE_CR,    1'b0, CODE_LF,  1'b1},
		'{8'h20, 1'b0, 1'b1, 2'd1, CODE_SPACE, 1'b1, CODE_NUL, 1'b0},
		'{8'h3B, 1'b0, 1'b0, 2'd0, CODE_NUL,   1'b0, CODE_NUL, 1'b0},
		'{8'h45, 1'b1, 1'b0, 2'd0, CODE_NUL,   1'b0, CODE_NUL, 1'b0},
		'{8'h33, 1'b1, 1'b0, 2'd0, CODE_NUL,   1'b0, CODE_NUL, 1'b0},
		'{8'h5A, 1'b0, 1'b0, 2'd0, CODE_NUL,   1'b0, CODE_NUL, 1'b0},
		'{8'h20, 1'b1, 1'b1, 2'd1, CODE_SPACE, 1'b1, CODE_NUL, 1'b0},
		'{8'h3F, 1'b0, 1'b0, 2'd0, CODE_NUL,   1'b0, CODE_NUL, 1'b0},
		'{8'h7B, 1'b0, 1'b1, 2'd0, CODE_NUL,   1'b0, CODE_NUL, 1'b0},
		'{8'h60, 1'b0, 1'b1, 2'd0, CODE_NUL,   1'b0, CODE_NUL, 1'b0},
		'{8'h56, 1'b1, 1'b0, 2'd0, CODE_NUL,   1'b0, CODE_NUL, 1'b0},
		'{8'h7F, 1'b0, 1'b1, 2'd0, CODE_NUL,   1'b0, CODE_NUL, 1'b0},
		'{8'h00, 1'b1, 1'b1, 2'd1, CODE_NUL,   1'b1, CODE_NUL, 1'b0},
		'{8'h4D, 1'b0, 1'b0, 2'd0, CODE_NUL,   1'b0, CODE_NUL, 1'b0},
		'{8'h40, 1'b1, 1'b1, 2'd0, CODE_NUL,   1'b0, CODE_NUL, 1'b0},
		'{8'h4D, 1'b0, 1'b0, 2'd0, CODE_NUL,   1'b0, CODE_NUL, 1'b0}
	};

	logic clk;
	logic arst_n;

	a2b_char_if char_bus ();
	a2b_code_if code_bus ();

	ascii_to_baudot_encoder uut (
		.clk    (clk),
		.arst_n (arst_n),
		.src_ch (char_bus.sink),
		.res_ch (code_bus.source)
	);

	shift_t     shift_now;
	queue_ent_t pending_codes[$];
	int         err_count;
	int         burst_left;
	int         stall_mode;
	int         stall_hold;
	int         rx_cycle;

	// clock
	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	task automatic report_fault(input string msg);
		$display("%0t ns: %s", $time, msg);
		err_count++;
	endtask

	// position of a character in a shift row, -1 when absent
	function automatic int row_pos(input logic [8*31-1:0] row, input logic [CHAR_W-1:0] c);
		logic [CHAR_W-1:0] ent;
		for (int i = 0; i < 31; i++) begin
			ent = row[8*(30-i) +: 8];
			if (ent != 8'h00 && ent == c)
				return i;
		end
		return -1;
	endfunction

	// predicted baudot codes for one character, tracking the remote shift
	task automatic encode_char(input logic [CHAR_W-1:0] ch, input logic rs, output int n,
			output queue_ent_t r0, output queue_ent_t r1);
		logic [CHAR_W-1:0] c;
		int pos;
		c = ch;
		n = 0;
		r0 = '0;
		r1 = '0;
		if (rs)
			shift_now = SHIFT_UNKNOWN;
		if (c >= ASCII_LOWER_A && c <= ASCII_LOWER_Z)
			c = c - ASCII_CASE;
		if (c == ASCII_NUL) begin
			n = 1;
			r0 = '{CODE_NUL, 1'b1};
		end else if (c == ASCII_CR) begin
			n = 1;
			r0 = '{CODE_CR, 1'b1};
		end else if (c == ASCII_LF) begin
			n = 2;
			r0 = '{CODE_CR, 1'b0};
			r1 = '{CODE_LF, 1'b1};
		end else if (c == ASCII_SPACE) begin
			n = 1;
			r0 = '{CODE_SPACE, 1'b1};
		end else begin
			pos = row_pos(LETTER_ROW, c);
			if (pos >= 0) begin
				if (shift_now != SHIFT_LETTERS) begin
					shift_now = SHIFT_LETTERS;
					n = 2;
					r0 = '{CODE_LTRS, 1'b0};
					r1 = '{pos[CODE_W-1:0], 1'b1};
				end else begin
					n = 1;
					r0 = '{pos[CODE_W-1:0], 1'b1};
				end
			end else begin
				pos = row_pos(FIGURE_ROW, c);
				if (pos >= 0) begin
					if (shift_now != SHIFT_FIGURES) begin
						shift_now = SHIFT_FIGURES;
						n = 2;
						r0 = '{CODE_FIGS, 1'b0};
						r1 = '{pos[CODE_W-1:0], 1'b1};
					end else begin
						n = 1;
						r0 = '{pos[CODE_W-1:0], 1'b1};
					end
				end
			end
		end
	endtask

	// one character beat, with bursts and gaps; called and left at a falling edge
	task automatic send_char(input logic [CHAR_W-1:0] ch, input logic rs, input logic typed,
			input int tn, input queue_ent_t t0, input queue_ent_t t1, output int produced);
		int gap;
		int n;
		queue_ent_t r0;
		queue_ent_t r1;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				char_bus.valid = 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		char_bus.valid = 1'b1;
		char_bus.ascii_char = ch;
		char_bus.resync_shift = rs;
		do
			@(posedge clk);
		while (!char_bus.ready);
		encode_char(ch, rs, n, r0, r1);
		if (typed) begin
			if (tn > 0) pending_codes.push_back(t0);
			if (tn > 1) pending_codes.push_back(t1);
		end else begin
			if (n > 0) pending_codes.push_back(r0);
			if (n > 1) pending_codes.push_back(r1);
		end
		produced = n;
		@(negedge clk);
	endtask

	// random character: mostly text, some control, some raw bytes
	task automatic pick_char(output logic [CHAR_W-1:0] ch, output logic rs);
		int sel;
		int pos;
		sel = $urandom_range(0, 99);
		if (sel < 70) begin
			do
				pos = $urandom_range(0, 30);
			while (((sel < 45) ? LETTER_ROW[8*(30-pos) +: 8] : FIGURE_ROW[8*(30-pos) +: 8])
				== 8'h00);
			if (sel < 45) begin
				ch = LETTER_ROW[8*(30-pos) +: 8];
				if ($urandom_range(0, 1))
					ch = ch + ASCII_CASE;
			end else begin
				ch = FIGURE_ROW[8*(30-pos) +: 8];
			end
		end else if (sel < 82) begin
			case ($urandom_range(0, 3))
				0: ch = ASCII_NUL;
				1: ch = ASCII_CR;
				2: ch = ASCII_LF;
				default: ch = ASCII_SPACE;
			endcase
		end else begin
			ch = CHAR_W'($urandom_range(0, 255));
		end
		rs = ($urandom_range(0, 9) == 0);
	endtask

	// receiver stall pattern, with a mode that is drawn anew at random
	always @(negedge clk) begin
		rx_cycle++;
		if (rx_cycle % 100 == 0)
			stall_mode = $urandom_range(0, 3);
		case (stall_mode)
			0: code_bus.ready = 1'b1;
			1: code_bus.ready = 1'($urandom_range(0, 1));
			2: code_bus.ready = (rx_cycle % 3 == 0);
			default: begin
				if (stall_hold == 0) begin
					stall_hold = $urandom_range(1, 8);
					code_bus.ready = ~code_bus.ready;
				end
				stall_hold--;
			end
		endcase
	end

	// compare each code beat with the oldest expected code
	always @(posedge clk) begin
		queue_ent_t exp_code;
		if (arst_n && code_bus.valid && code_bus.ready) begin
			if (pending_codes.size() == 0) begin
				report_fault($sformatf("unexpected code beat %0d last %0b",
					code_bus.baudot_code, code_bus.last_of_run));
			end else begin
				exp_code = pending_codes.pop_front();
				if (code_bus.baudot_code !== exp_code.code)
					report_fault($sformatf("baudot_code %0d, expected %0d",
						code_bus.baudot_code, exp_code.code));
				if (code_bus.last_of_run !== exp_code.last)
					report_fault($sformatf("last_of_run %0b, expected %0b",
						code_bus.last_of_run, exp_code.last));
			end
		end
	end

	// stimulus and end of run
	initial begin
		logic [CHAR_W-1:0] ch;
		logic rs;
		int produced;
		int hits;
		arst_n = 1'b0;
		char_bus.valid = 1'b0;
		char_bus.ascii_char = '0;
		char_bus.resync_shift = 1'b0;
		code_bus.ready = 1'b0;
		shift_now = SHIFT_UNKNOWN;
		err_count = 0;
		burst_left = 0;
		stall_mode = 0;
		stall_hold = 0;
		rx_cycle = 0;
		hits = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed table
		for (int i = 0; i < DIR_ROWS; i++)
			send_char(dir_rows[i].ch, dir_rows[i].rs, dir_rows[i].typed, dir_rows[i].n,
				'{dir_rows[i].c0, dir_rows[i].l0}, '{dir_rows[i].c1, dir_rows[i].l1},
				produced);

		// random text; characters with no code do not count
		while (hits < RANDOM_HITS) begin
			pick_char(ch, rs);
			send_char(ch, rs, 1'b0, 0, '0, '0, produced);
			if (produced > 0)
				hits++;
		end
		char_bus.valid = 1'b0;

		while (pending_codes.size() != 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);
		if (err_count == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

	// watchdog
	initial begin
		#5000000;
		$display("tb_top: errors");
		$finish;
	end

endmodule
